>>> rtl/core/sbdsp_pkg.sv
`timescale 1ns / 1ps

package sbdsp_pkg;

  // Field widths
  localparam int unsigned NUM_BUTTONS = 6;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned SETTLE_W    = 24;
  localparam int unsigned KEY_W       = 3;

  // Reset values
  localparam logic [SETTLE_W-1:0]    SETTLE_RESET = SETTLE_W'(25000);
  localparam logic [NUM_BUTTONS-1:0] BTN_RELEASED = '1;

  // One poll of the buttons
  typedef struct packed {
    logic [NUM_BUTTONS-1:0] buttons;
    logic [TIME_W-1:0]      now;
    logic [GEN_W-1:0]       gen;
  } sample_t;

endpackage

>>> rtl/core/sbdsp_in_stage.sv
`timescale 1ns / 1ps

module sbdsp_in_stage
  import sbdsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NUM_BUTTONS-1:0] buttons_raw_i,
  input  logic [TIME_W-1:0]      now_us_i,
  input  logic [GEN_W-1:0]       prompt_gen_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output sample_t                sample_o
);

  logic    valid_q, valid_d;
  sample_t sample_q;
  logic    load;

  // Register takes a new transfer when empty or drained this cycle
  assign load       = !valid_q || take_i;
  assign in_stall_o = !load;
  assign valid_d    = load ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      sample_q <= '{buttons: buttons_raw_i, now: now_us_i, gen: prompt_gen_i};
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

>>> rtl/core/sbdsp_update.sv
`timescale 1ns / 1ps

module sbdsp_update
  import sbdsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SETTLE_W-1:0]    cfg_wdata_i,
  input  logic                   valid_i,
  input  sample_t                sample_i,
  output logic                   take_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   key_valid_o,
  output logic [KEY_W-1:0]       key_code_o,
  output logic [NUM_BUTTONS-1:0] stable_buttons_o
);

  logic [SETTLE_W-1:0]    settle_q;
  logic [NUM_BUTTONS-1:0] deb_q, deb_d;
  logic [NUM_BUTTONS-1:0] cand_q;
  logic [TIME_W-1:0]      change_q, change_d;
  logic [GEN_W-1:0]       gen_q;
  logic                   armed_q, armed_d;

  logic                   out_valid_q;
  logic                   key_valid_q, key_valid_d;
  logic [KEY_W-1:0]       key_code_q, key_code_d;
  logic [NUM_BUTTONS-1:0] stable_q;

  logic                   gen_chg, smp_chg;
  logic [TIME_W-1:0]      elapsed;
  logic                   old_settled, settle_zero, arm_settled, deb_settled;
  logic                   deb_upd, arm_set;
  logic [NUM_BUTTONS-1:0] pressed;
  logic                   single;

  // Result register is free when empty or being drained
  assign take_o = valid_i && (!out_valid_q || !out_stall_i);

  // Elapsed time since last change, modulo 2^64
  assign gen_chg     = sample_i.gen != gen_q;
  assign smp_chg     = sample_i.buttons != cand_q;
  assign elapsed     = sample_i.now - change_q;
  assign settle_zero = settle_q == '0;
  assign old_settled = (elapsed[TIME_W-1:SETTLE_W] != '0) ||
                       (elapsed[SETTLE_W-1:0] >= settle_q);
  // A restart of the timer leaves zero elapsed time
  assign arm_settled = gen_chg ? settle_zero : old_settled;
  assign deb_settled = (gen_chg || smp_chg) ? settle_zero : old_settled;

  // Re-arm once everything is released and settled
  assign arm_set = (sample_i.buttons == BTN_RELEASED) && !smp_chg && arm_settled;
  assign armed_d = arm_set || (armed_q && !gen_chg);

  assign change_d = (gen_chg || smp_chg) ? sample_i.now : change_q;

  // Debounced update and single-press detection
  assign deb_upd = (sample_i.buttons != deb_q) && deb_settled;
  assign deb_d   = deb_upd ? sample_i.buttons : deb_q;
  assign pressed = deb_q & ~sample_i.buttons;
  assign single  = (pressed != '0) && ((pressed & (pressed - 1'b1)) == '0);

  assign key_valid_d = deb_upd && armed_d && single;

  always_comb begin
    key_code_d = '0;
    if (key_valid_d) begin
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
        if (pressed[i]) begin
          key_code_d = KEY_W'(i);
        end
      end
    end
  end

  // Settle time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_RESET;
    end else if (cfg_we_i) begin
      settle_q <= cfg_wdata_i;
    end
  end

  // Debouncer state, advanced once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= BTN_RELEASED;
      cand_q   <= BTN_RELEASED;
      change_q <= '0;
      gen_q    <= '0;
      armed_q  <= 1'b1;
    end else if (take_o) begin
      deb_q    <= deb_d;
      cand_q   <= sample_i.buttons;
      change_q <= change_d;
      gen_q    <= sample_i.gen;
      armed_q  <= armed_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      key_valid_q <= key_valid_d;
      key_code_q  <= key_code_d;
      stable_q    <= deb_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign key_valid_o      = key_valid_q;
  assign key_code_o       = key_code_q;
  assign stable_buttons_o = stable_q;

endmodule

>>> rtl/core/six_button_debounce_single_press.sv
`timescale 1ns / 1ps

// Six-button debouncer with single-press key reporting.
// Input channel (in_valid_i / in_stall_o) carries one poll: active-low
// buttons, a microsecond timestamp and the prompt generation. A transfer
// happens on a rising edge with valid high and stall low.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// poll: key_valid, key_code and the debounced button state.
// A poll is registered in the input register, then processed and moved into the
// result register, whose contents drive the outputs.
// Throughput: one poll per cycle while the receiver does not stall; the state
// update is one 64-bit subtract and compare between these two registers.
// When the receiver stalls, the result holds and the input register keeps one
// more poll; after that in_stall_o rises until the result is taken.
// Reset: debounced and candidate state all released, timer and generation
// zero, reporting armed, settle time 25000 us, both channels empty.
// cfg_we_i writes the settle time; write it only while the block is idle.
module six_button_debounce_single_press
  import sbdsp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [SETTLE_W-1:0]    cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NUM_BUTTONS-1:0] buttons_raw_i,
  input  logic [TIME_W-1:0]      now_us_i,
  input  logic [GEN_W-1:0]       prompt_gen_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   key_valid_o,
  output logic [KEY_W-1:0]       key_code_o,
  output logic [NUM_BUTTONS-1:0] stable_buttons_o
);

  logic    s1_valid;
  sample_t s1_sample;
  logic    take;

  // Input register
  sbdsp_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .buttons_raw_i (buttons_raw_i),
    .now_us_i      (now_us_i),
    .prompt_gen_i  (prompt_gen_i),
    .take_i        (take),
    .valid_o       (s1_valid),
    .sample_o      (s1_sample)
  );

  // State update and result register
  sbdsp_update u_update (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .valid_i          (s1_valid),
    .sample_i         (s1_sample),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_valid_o      (key_valid_o),
    .key_code_o       (key_code_o),
    .stable_buttons_o (stable_buttons_o)
  );

endmodule

>>> tb/six_button_debounce_single_press_test.sv
`timescale 1ns / 1ps

module six_button_debounce_single_press_test;
  import sbdsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 29;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX = '1;

  // Key codes match the button bit positions
  typedef enum logic [KEY_W-1:0] {
    KEY_UP, KEY_LEFT, KEY_DOWN, KEY_RIGHT, KEY_SELECT, KEY_BACK
  } key_e;

  typedef struct packed {
    logic                   kv;
    logic [KEY_W-1:0]       code;
    logic [NUM_BUTTONS-1:0] stable;
  } key_event_t;

  // DUT ports, all inputs known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [SETTLE_W-1:0]    cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [NUM_BUTTONS-1:0] buttons_raw_i = '0;
  logic [TIME_W-1:0]      now_us_i = '0;
  logic [GEN_W-1:0]       prompt_gen_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   key_valid_o;
  logic [KEY_W-1:0]       key_code_o;
  logic [NUM_BUTTONS-1:0] stable_buttons_o;

  six_button_debounce_single_press dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .buttons_raw_i    (buttons_raw_i),
    .now_us_i         (now_us_i),
    .prompt_gen_i     (prompt_gen_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .key_valid_o      (key_valid_o),
    .key_code_o       (key_code_o),
    .stable_buttons_o (stable_buttons_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Debouncer state mirrored by the predictor
  logic [SETTLE_W-1:0]    settle_model = SETTLE_RESET;
  logic [NUM_BUTTONS-1:0] db_state     = BTN_RELEASED;
  logic [NUM_BUTTONS-1:0] cand         = BTN_RELEASED;
  logic [TIME_W-1:0]      t_change     = '0;
  logic [GEN_W-1:0]       gen_seen     = '0;
  logic                   armed        = 1'b1;

  sample_t    poll_q[$];
  key_event_t key_q[$];

  // Stimulus bookkeeping
  logic [TIME_W-1:0]      poll_now  = '0;
  logic [GEN_W-1:0]       poll_gen  = '0;
  logic [NUM_BUTTONS-1:0] last_b    = BTN_RELEASED;
  int unsigned            queued    = 0;
  int unsigned            keys_seen = 0;
  int unsigned            results   = 0;
  int unsigned            errors    = 0;
  int unsigned            cycles    = 0;
  bit                     quiet     = 1'b0;
  bit                     hold_req  = 1'b0;

  // One poll through the debouncer; returns the result it should produce
  function automatic key_event_t debounce_poll(input sample_t p);
    key_event_t             r;
    logic [NUM_BUTTONS-1:0] pressed;
    int                     i;
    r = '0;
    if (p.gen != gen_seen) begin
      gen_seen = p.gen;
      armed    = 1'b0;
      t_change = p.now;
    end
    if (p.buttons == BTN_RELEASED && cand == p.buttons &&
        (p.now - t_change) >= TIME_W'(settle_model)) begin
      armed = 1'b1;
    end
    if (p.buttons != cand) begin
      cand     = p.buttons;
      t_change = p.now;
    end
    if (p.buttons != db_state && (p.now - t_change) >= TIME_W'(settle_model)) begin
      pressed  = db_state & ~p.buttons;
      db_state = p.buttons;
      if (armed && $onehot(pressed)) begin
        r.kv = 1'b1;
        // lowest pressed bit wins (only one is set anyway)
        for (i = NUM_BUTTONS - 1; i >= 0; i--) begin
          if (pressed[i]) r.code = KEY_W'(i);
        end
      end
    end
    r.stable = db_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // Sender: offers the next queued poll, idles at random
  always @(posedge clk_i or negedge rst_ni) begin : driver_p
    sample_t head;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (poll_q.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        head = poll_q.pop_front();
        in_valid_i    <= 1'b1;
        buttons_raw_i <= head.buttons;
        now_us_i      <= head.now;
        prompt_gen_i  <= head.gen;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : stall_p
    int unsigned hold_left;
    bit          hold_done;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk_i) begin : monitor_p
    sample_t    taken;
    key_event_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        taken.buttons = buttons_raw_i;
        taken.now     = now_us_i;
        taken.gen     = prompt_gen_i;
        key_q.push_back(debounce_poll(taken));
      end
      if (out_valid_o && !out_stall_i) begin
        results++;
        if (key_q.size() == 0) begin
          report_mismatch("result with nothing pending", stable_buttons_o, 0);
        end else begin
          want = key_q.pop_front();
          if (key_valid_o !== want.kv)
            report_mismatch("key_valid", key_valid_o, want.kv);
          if (key_code_o !== want.code)
            report_mismatch("key_code", key_code_o, want.code);
          if (stable_buttons_o !== want.stable)
            report_mismatch("stable_buttons", stable_buttons_o, want.stable);
          if (key_valid_o === 1'b1) keys_seen++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, key_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Queue one poll, advancing the poll clock by dt (wraps mod 2^64)
  task automatic poll(input logic [NUM_BUTTONS-1:0] b, input logic [TIME_W-1:0] dt);
    sample_t p;
    poll_now += dt;
    p.buttons = b;
    p.now     = poll_now;
    p.gen     = poll_gen;
    poll_q.push_back(p);
    last_b = b;
    queued++;
  endtask

  // Time steps just under and at or past the settle time
  function automatic logic [TIME_W-1:0] short_dt();
    int unsigned s;
    s = settle_model;
    if (s == 0) return '0;
    if ($urandom_range(0, 3) == 0) return TIME_W'(s - 1);
    return TIME_W'($urandom_range(0, s - 1));
  endfunction

  function automatic logic [TIME_W-1:0] long_dt();
    int unsigned s;
    s = settle_model;
    case ($urandom_range(0, 3))
      0:       return TIME_W'(s);
      1:       return TIME_W'(s + 1);
      default: return TIME_W'(s + $urandom_range(0, s / 2 + 5));
    endcase
  endfunction

  // Wait until the block has drained, then a little spare idle time
  task automatic wait_idle();
    @(negedge clk_i);
    while (poll_q.size() != 0 || in_valid_i || key_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_settle(input logic [SETTLE_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    settle_model = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random polls, mostly clean press/release sequences with bounce
  task automatic random_polls(input int unsigned n);
    int unsigned            stop;
    int unsigned            sel;
    int unsigned            k;
    int unsigned            j;
    logic [NUM_BUTTONS-1:0] m;
    stop = queued + n;
    while (queued < stop) begin
      sel = $urandom_range(0, 99);
      k   = $urandom_range(0, NUM_BUTTONS - 1);
      if (sel < 55) begin
        // settle released, single press with bounce, then release
        poll(BTN_RELEASED, long_dt());
        poll(BTN_RELEASED, long_dt());
        m = BTN_RELEASED & ~(NUM_BUTTONS'(1) << k);
        for (j = $urandom_range(0, 2); j != 0; j--) poll(NUM_BUTTONS'($urandom()), short_dt());
        poll(m, short_dt());
        poll(m, long_dt());
        for (j = $urandom_range(0, 2); j != 0; j--) poll(NUM_BUTTONS'($urandom()), short_dt());
        poll(BTN_RELEASED, short_dt());
        poll(BTN_RELEASED, long_dt());
      end else if (sel < 70) begin
        // chord, or one more key on top of those held
        m = $urandom_range(0, 1) ? last_b & ~(NUM_BUTTONS'(1) << k)
                                 : NUM_BUTTONS'($urandom());
        poll(m, short_dt());
        poll(m, long_dt());
      end else if (sel < 80) begin
        // new prompt generation
        case ($urandom_range(0, 2))
          0:       poll_gen = poll_gen + 1;
          1:       poll_gen = '1;
          default: poll_gen = $urandom();
        endcase
        poll(last_b, short_dt());
      end else if (sel < 90) begin
        // noise
        poll(NUM_BUTTONS'($urandom()), $urandom_range(0, 1) ? short_dt() : long_dt());
      end else begin
        // time jumps, backwards and across the wrap
        case ($urandom_range(0, 2))
          0: poll_now = {$urandom(), $urandom()};
          1: poll_now = {32'hFFFF_FFFF, 32'hFFFF_FFFF - $urandom_range(0, 2 * settle_model)};
          default: poll_now = poll_now - $urandom_range(1, 1000);
        endcase
        poll(last_b, $urandom_range(0, 1) ? short_dt() : long_dt());
      end
    end
  endtask

  initial begin : stimulus_p
    int k;
    logic [NUM_BUTTONS-1:0] held;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settle time: each key pressed in turn on top of the others
    poll(BTN_RELEASED, 10);
    held = BTN_RELEASED;
    for (k = KEY_UP; k <= KEY_BACK; k++) begin
      held[k] = 1'b0;
      poll(held, 1000);
      poll(held, 25000);
    end
    // releases only, then a chord
    poll(BTN_RELEASED, 50);
    poll(BTN_RELEASED, 25000);
    poll(6'h30, 5);
    poll(6'h30, 25000);
    poll(BTN_RELEASED, 5);
    poll(BTN_RELEASED, 25000);
    // new generation disarms: this press is not reported
    poll_gen = '1;
    poll(BTN_RELEASED & ~(NUM_BUTTONS'(1) << KEY_DOWN), 5);
    poll(BTN_RELEASED & ~(NUM_BUTTONS'(1) << KEY_DOWN), 25000);
    // time running backwards reads as long elapsed
    poll(BTN_RELEASED, 5);
    poll(BTN_RELEASED, 64'hFFFF_FFFF_FFFF_FFF0);

    // Zero settle: samples count on first sight
    write_settle('0);
    poll(BTN_RELEASED, 1);
    poll(BTN_RELEASED & ~(NUM_BUTTONS'(1) << KEY_RIGHT), 0);
    poll(BTN_RELEASED, 0);
    random_polls(300);

    write_settle(SETTLE_MAX);
    random_polls(300);

    // Small settle, no idling anywhere, long receiver hold-off up front
    write_settle(10);
    @(negedge clk_i);
    quiet    = 1'b1;
    hold_req = 1'b1;
    random_polls(400);
    wait_idle();
    quiet = 1'b0;

    write_settle(SETTLE_W'($urandom_range(1, 100)));
    random_polls(300);
    write_settle(SETTLE_W'($urandom()));
    random_polls(300);
    write_settle(SETTLE_RESET);
    random_polls(300);

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d polls, %0d results, %0d key reports, %0d mismatches",
             queued, results, keys_seen, errors);
    $display("Settle times: reset, zero, max, small and random; hold-off and wrap exercised");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
